// ----- rtl/lscs_pkg.sv -----
// Shared types and constants for the lidar scan cylinder segmenter.
// No dependencies; every other file in rtl except lscs_checker.sv imports this package.
package lscs_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [25:0] QUARTER_TURN = 26'sd4194304;
  localparam logic signed [25:0] HALF_TURN = 26'sd8388608;
  localparam logic signed [20:0] COORD_LIMIT = 21'sd65535;

  localparam logic [2:0] REG_ANGLE_START = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP = 3'd1;
  localparam logic [2:0] REG_RANGE_LIMIT = 3'd2;
  localparam logic [2:0] REG_GAP_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_TARGET_DIAMETER = 3'd4;
  localparam logic [2:0] REG_DIAMETER_TOL = 3'd5;

  typedef struct packed {
    logic [15:0] angle_start;
    logic [15:0] angle_step;
    logic [15:0] range_limit_mm;
    logic [15:0] gap_threshold_mm;
    logic [15:0] target_diameter_mm;
    logic [15:0] diameter_tolerance_mm;
  } cfg_t;

  // One classified sample handed from the front end to the back end.
  typedef struct packed {
    logic [15:0] range_mm;
    logic [15:0] angle;
    logic        usable;
    logic        last;
  } samp_t;

  function automatic logic signed [25:0] atan_entry(input logic [3:0] i);
    logic signed [25:0] v;
    case (i)
      4'd0: v = 26'sd2097152;
      4'd1: v = 26'sd1238021;
      4'd2: v = 26'sd654136;
      4'd3: v = 26'sd332050;
      4'd4: v = 26'sd166669;
      4'd5: v = 26'sd83416;
      4'd6: v = 26'sd41718;
      4'd7: v = 26'sd20860;
      4'd8: v = 26'sd10430;
      4'd9: v = 26'sd5215;
      4'd10: v = 26'sd2608;
      4'd11: v = 26'sd1304;
      4'd12: v = 26'sd652;
      4'd13: v = 26'sd326;
      4'd14: v = 26'sd163;
      4'd15: v = 26'sd81;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/lscs_front.sv -----
// Front end: takes samples, tracks the sample index and computes the angle and the usable flag.
// Depends on lscs_pkg.
module lscs_front import lscs_pkg::*; #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        push,
  input  logic [15:0] range_mm,
  input  logic        range_valid,
  input  logic        scan_last,
  input  logic        q_full,
  output logic        q_push,
  output samp_t       q_data
);

  localparam int IDX_W = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;

  logic [IDX_W-1:0] sample_index;
  logic [31:0]      step_prod;

  assign q_push = push && !q_full;
  assign step_prod = {16'd0, cfg.angle_step} * 32'(sample_index);

  always_comb begin
    q_data.range_mm = range_mm;
    q_data.angle = cfg.angle_start + step_prod[15:0];
    q_data.usable = range_valid && (range_mm < cfg.range_limit_mm);
    q_data.last = scan_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
    end else if (q_push) begin
      if (scan_last || sample_index == IDX_W'(MAX_SAMPLES - 1)) begin
        sample_index <= '0;
      end else begin
        sample_index <= sample_index + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/lscs_queue.sv -----
// Two-entry queue between the front end and the back end.
// Depends on lscs_pkg for the entry type.
module lscs_queue import lscs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  samp_t wdata,
  input  logic  rd,
  output samp_t rdata,
  output logic  full,
  output logic  empty
);

  samp_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ----- rtl/lscs_back.sv -----
// Back end: CORDIC point conversion, segment chaining, chord test and result register.
// Depends on lscs_pkg.
module lscs_back import lscs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  samp_t              q_data,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic               found,
  output logic signed [16:0] center_x_mm,
  output logic signed [16:0] center_y_mm
);

  typedef enum logic [3:0] {
    B_IDLE, B_ROT, B_MUL, B_PT, B_SQ, B_UPD, B_CDIFF, B_CSQ, B_CEVAL, B_OUT
  } bstate_t;

  bstate_t state;
  samp_t   cur;

  logic signed [33:0] cx_r, cy_r;
  logic signed [25:0] z;
  logic [3:0]         iter;
  logic               flip;
  logic signed [50:0] prod_x, prod_y;
  logic signed [16:0] px, py;
  logic signed [17:0] dx, dy, ex, ey;
  logic [35:0]        d2, c2;
  logic [33:0]        hi2;
  logic [31:0]        lo2, g2;
  logic               lo_pos;

  logic [1:0]         seg_points;
  logic signed [16:0] first_x, first_y, prev_x, prev_y;
  logic               hit_flag;
  logic signed [16:0] hit_x, hit_y;

  logic signed [25:0] z_init;
  logic signed [33:0] x_sh, y_sh, xf, yf;
  logic signed [20:0] sx, sy;
  logic signed [16:0] px_c, py_c;
  logic signed [17:0] sum_x, sum_y, lo;
  logic [16:0]        hi;
  logic               chord_ok;

  assign q_pop = (state == B_IDLE) && !q_empty;
  assign z_init = 26'(signed'(q_data.angle)) * 26'sd256;
  assign x_sh = cx_r >>> iter;
  assign y_sh = cy_r >>> iter;
  assign xf = flip ? -cx_r : cx_r;
  assign yf = flip ? -cy_r : cy_r;
  assign sx = prod_x[50:30];
  assign sy = prod_y[50:30];
  assign px_c = (sx > COORD_LIMIT) ? 17'sd65535 : (sx < -COORD_LIMIT) ? -17'sd65535 : sx[16:0];
  assign py_c = (sy > COORD_LIMIT) ? 17'sd65535 : (sy < -COORD_LIMIT) ? -17'sd65535 : sy[16:0];
  assign sum_x = 18'(first_x) + 18'(prev_x);
  assign sum_y = 18'(first_y) + 18'(prev_y);
  assign hi = {1'b0, cfg.target_diameter_mm} + {1'b0, cfg.diameter_tolerance_mm};
  assign lo = $signed({2'b0, cfg.target_diameter_mm}) - $signed({2'b0, cfg.diameter_tolerance_mm});
  assign chord_ok = (seg_points == 2'd2) && (c2 <= {2'b0, hi2}) && (!lo_pos || c2 >= {4'b0, lo2});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      seg_points <= 2'd0;
      hit_flag <= 1'b0;
      empty <= 1'b1;
      first_x <= '0;
      first_y <= '0;
      prev_x <= '0;
      prev_y <= '0;
    end else begin
      if (pop && !empty) begin
        empty <= 1'b1;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cur <= q_data;
            iter <= 4'd0;
            cx_r <= CORDIC_START;
            cy_r <= '0;
            // Fold angles beyond a quarter turn by a half turn.
            if (z_init > QUARTER_TURN) begin
              z <= z_init - HALF_TURN;
              flip <= 1'b1;
            end else if (z_init < -QUARTER_TURN) begin
              z <= z_init + HALF_TURN;
              flip <= 1'b1;
            end else begin
              z <= z_init;
              flip <= 1'b0;
            end
            if (!hit_flag && q_data.usable) begin
              state <= B_ROT;
            end else if (q_data.last) begin
              state <= hit_flag ? B_OUT : B_CDIFF;
            end
          end
        end
        B_ROT: begin
          if (z >= 0) begin
            cx_r <= cx_r - y_sh;
            cy_r <= cy_r + x_sh;
            z <= z - atan_entry(iter);
          end else begin
            cx_r <= cx_r + y_sh;
            cy_r <= cy_r - x_sh;
            z <= z + atan_entry(iter);
          end
          iter <= iter + 4'd1;
          if (iter == 4'(CORDIC_STEPS - 1)) begin
            state <= B_MUL;
          end
        end
        B_MUL: begin
          prod_x <= $signed({35'd0, cur.range_mm}) * 51'(xf);
          prod_y <= $signed({35'd0, cur.range_mm}) * 51'(yf);
          state <= B_PT;
        end
        B_PT: begin
          px <= px_c;
          py <= py_c;
          dx <= 18'(px_c) - 18'(prev_x);
          dy <= 18'(py_c) - 18'(prev_y);
          ex <= 18'(prev_x) - 18'(first_x);
          ey <= 18'(prev_y) - 18'(first_y);
          state <= B_SQ;
        end
        B_SQ, B_CSQ: begin
          d2 <= 36'(dx * dx) + 36'(dy * dy);
          c2 <= 36'(ex * ex) + 36'(ey * ey);
          g2 <= cfg.gap_threshold_mm * cfg.gap_threshold_mm;
          hi2 <= hi * hi;
          lo2 <= lo[15:0] * lo[15:0];
          lo_pos <= lo > 0;
          state <= (state == B_SQ) ? B_UPD : B_CEVAL;
        end
        B_UPD: begin
          if (seg_points == 2'd0) begin
            first_x <= px;
            first_y <= py;
            seg_points <= 2'd1;
          end else if (d2 < {4'b0, g2}) begin
            if (seg_points != 2'd2) begin
              seg_points <= seg_points + 2'd1;
            end
          end else begin
            // The gap closes the open segment before this point starts a new one.
            if (chord_ok) begin
              hit_flag <= 1'b1;
              hit_x <= sum_x[17:1];
              hit_y <= sum_y[17:1];
            end
            first_x <= px;
            first_y <= py;
            seg_points <= 2'd1;
          end
          prev_x <= px;
          prev_y <= py;
          if (cur.last) begin
            state <= B_CDIFF;
          end else begin
            state <= B_IDLE;
          end
        end
        B_CDIFF: begin
          ex <= 18'(prev_x) - 18'(first_x);
          ey <= 18'(prev_y) - 18'(first_y);
          dx <= '0;
          dy <= '0;
          state <= hit_flag ? B_OUT : B_CSQ;
        end
        B_CEVAL: begin
          if (chord_ok) begin
            hit_flag <= 1'b1;
            hit_x <= sum_x[17:1];
            hit_y <= sum_y[17:1];
          end
          state <= B_OUT;
        end
        B_OUT: begin
          if (empty) begin
            empty <= 1'b0;
            found <= hit_flag;
            center_x_mm <= hit_flag ? hit_x : 17'sd0;
            center_y_mm <= hit_flag ? hit_y : 17'sd0;
            hit_flag <= 1'b0;
            seg_points <= 2'd0;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/lidar_scan_cylinder_segmenter.sv -----
// Lidar scan cylinder segmenter: sample queue in, one result per scan out.
// Channels: push/full accepts one range sample (range_mm, range_valid,
// scan_last). A two-entry queue decouples the front end from the back end.
// Results: one transaction per scan, shown while empty is low and taken by
// pop; found says whether a cylinder segment was seen, with its center.
// Configuration: cfg_we writes cfg_data into register cfg_addr.
// Back end: a usable sample passes queue read, 16 CORDIC iterations, product,
// clamp, squares and segment update; a skipped sample is only read from the
// queue. The last sample of a scan adds the final chord test and the result
// register. The sequential back end, chiefly the iterative CORDIC, sets the rate.
// Reset clears the queue, the sample index and the segment state, and marks the result empty.
// When the receiver does not pop, the back end holds in its output step and
// the queue fills; full then rises and inputs stall.
module lidar_scan_cylinder_segmenter import lscs_pkg::*; #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        range_mm,
  input  logic               range_valid,
  input  logic               scan_last,
  input  logic               pop,
  output logic               empty,
  output logic               found,
  output logic signed [16:0] center_x_mm,
  output logic signed [16:0] center_y_mm,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_data
);

  cfg_t  cfg;
  samp_t fq_data, bq_data;
  logic  fq_push, bq_pop, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_start <= 16'h8000;
      cfg.angle_step <= 16'd16;
      cfg.range_limit_mm <= 16'd65535;
      cfg.gap_threshold_mm <= 16'd1000;
      cfg.target_diameter_mm <= 16'd300;
      cfg.diameter_tolerance_mm <= 16'd50;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ANGLE_START: cfg.angle_start <= cfg_data;
        REG_ANGLE_STEP: cfg.angle_step <= cfg_data;
        REG_RANGE_LIMIT: cfg.range_limit_mm <= cfg_data;
        REG_GAP_THRESHOLD: cfg.gap_threshold_mm <= cfg_data;
        REG_TARGET_DIAMETER: cfg.target_diameter_mm <= cfg_data;
        REG_DIAMETER_TOL: cfg.diameter_tolerance_mm <= cfg_data;
        default: ;
      endcase
    end
  end

  lscs_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .push(push), .range_mm(range_mm),
    .range_valid(range_valid), .scan_last(scan_last), .q_full(full),
    .q_push(fq_push), .q_data(fq_data)
  );

  lscs_queue u_queue (
    .clk(clk), .rst(rst), .wr(fq_push), .wdata(fq_data), .rd(bq_pop),
    .rdata(bq_data), .full(full), .empty(q_empty)
  );

  lscs_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(q_empty), .q_data(bq_data),
    .q_pop(bq_pop), .pop(pop), .empty(empty), .found(found),
    .center_x_mm(center_x_mm), .center_y_mm(center_y_mm)
  );

endmodule

// ----- rtl/lscs_checker.sv -----
// Port-level checks for the cylinder segmenter, bound to the top level.
// Depends on lidar_scan_cylinder_segmenter.
module lscs_props (
  input logic               clk,
  input logic               rst,
  input logic               pop,
  input logic               empty,
  input logic               full,
  input logic               found,
  input logic signed [16:0] center_x_mm,
  input logic signed [16:0] center_y_mm
);

  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("block not idle after reset");

  a_zero_center: assert property (@(posedge clk) disable iff (rst)
    (!empty && !found) |-> (center_x_mm == 17'sd0 && center_y_mm == 17'sd0))
    else $error("center nonzero without a hit");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(found) && $stable(center_x_mm) && $stable(center_y_mm)))
    else $error("waiting result changed");

endmodule

bind lidar_scan_cylinder_segmenter lscs_props u_lscs_props (
  .clk(clk), .rst(rst), .pop(pop), .empty(empty), .full(full), .found(found),
  .center_x_mm(center_x_mm), .center_y_mm(center_y_mm)
);
